/* rtl/cpr_pkg.sv */
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants for the clock page replacement block
// Holds the register width, the frame count floor and the structs that pass
// between the frame cells and the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

  // Width of the frame count register and its reset and floor value
  localparam int unsigned CFG_W      = 6;
  localparam int unsigned MIN_FRAMES = 3;

  // Per-cell commands from the controller
  typedef struct packed {
    logic capture;  // register the compare result for a new reference
    logic active;   // cell lies below the frame count
    logic load;     // write the page, mark valid, set the use bit
    logic set_use;  // set the use bit
    logic clr_use;  // clear the use bit
  } cell_ctrl_t;

  // Priority chain between neighbouring cells: something found lower down
  typedef struct packed {
    logic hit;
    logic empty;
  } chain_t;

endpackage : cpr_pkg

`default_nettype wire

/* rtl/cpr_cell.sv */
// ----------------------------------------------------------------------------
// cpr_cell: one physical frame of the clock policy
// Holds the resident page, its valid and use bits, compares a new reference
// against the page and takes part in the lowest-first priority chain.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_cell #(
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cpr_pkg::cell_ctrl_t  ctrl,
  input  wire logic [PAGE_BITS-1:0] page_in,
  input  wire cpr_pkg::chain_t      chain_in,
  output cpr_pkg::chain_t           chain_out,
  output cpr_pkg::chain_t           first,
  output logic [PAGE_BITS-1:0]      page_out,
  output logic                      use_out
);

  logic [PAGE_BITS-1:0] page_r;
  logic                 valid_r;
  logic                 use_r;
  logic                 match_r;
  logic                 hit_here;
  logic                 empty_here;

  // Frame contents: the page carries no reset, valid gates the compare against it
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      page_r <= page_in;
    end
  end

  // Valid, use and compare flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      use_r   <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctrl.load) begin
        valid_r <= 1'b1;
      end
      if (ctrl.load || ctrl.set_use) begin
        use_r <= 1'b1;
      end else if (ctrl.clr_use) begin
        use_r <= 1'b0;
      end
      if (ctrl.capture) begin
        match_r <= valid_r && (page_r == page_in);
      end
    end
  end

  // Pass the priority chain on: the lowest active cell that matches wins
  assign hit_here    = match_r && ctrl.active;
  assign empty_here  = !valid_r && ctrl.active;

  assign chain_out.hit   = chain_in.hit   || hit_here;
  assign chain_out.empty = chain_in.empty || empty_here;
  assign first.hit       = hit_here   && !chain_in.hit;
  assign first.empty     = empty_here && !chain_in.empty;

  assign page_out = page_r;
  assign use_out  = use_r;

endmodule : cpr_cell

`default_nettype wire

/* rtl/clock_page_replacement.sv */
// ----------------------------------------------------------------------------
// clock_page_replacement: second-chance (clock) page replacement
// A row of frame cells looks up each page reference in parallel; a controller
// fills empty frames or sweeps the clock hand to pick a victim.
//
//   channel | direction | ports                       | contents
//   in      | slave     | in_tvalid/tready/tdata      | page_number
//   out     | master    | out_tvalid/tready/tdata/tuser | result, tuser = hit
//   cfg     | slave     | cfg_valid/ready/data        | frames_in_use
//
// A hit or a fill of an empty frame compares in the cells on the input
// transfer, then does priority select and update. A replacing fault sweeps the
// hand, which clears set use bits one frame per cycle until it finds a clear one.
// Reset clears all valid and use bits at once; no clearing pass is needed.
// A stalled output holds the finished result; the next reference is taken
// once the current one has moved into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_page_replacement #(
  parameter int unsigned MAX_FRAMES = 32,
  parameter int unsigned PAGE_BITS  = 16,
  localparam int unsigned IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int unsigned IN_W      = ((PAGE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS  = IDX_W + 1 + PAGE_BITS + 64,
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // in_tdata: page_number
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [IN_W-1:0]           in_tdata,
  // out_tdata: slot, evicted_valid, evicted_page, fault_total, reference_total
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [OUT_W-1:0]               out_tdata,
  // out_tuser: hit
  output logic [0:0]                     out_tuser,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [cpr_pkg::CFG_W-1:0] cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CMP_W = (CNT_W > cpr_pkg::CFG_W) ? CNT_W : cpr_pkg::CFG_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SWEEP
  } state_t;

  state_t                     state_r;
  logic [cpr_pkg::CFG_W-1:0]  cfg_r;
  logic [PAGE_BITS-1:0]       page_r;
  logic [IDX_W-1:0]           hand_r;
  logic [31:0]                faults_r;
  logic [31:0]                refs_r;

  logic                       out_valid_r;
  logic                       hit_out_r;
  logic [IDX_W-1:0]           slot_out_r;
  logic                       ev_valid_out_r;
  logic [PAGE_BITS-1:0]       ev_page_out_r;
  logic [31:0]                faults_out_r;
  logic [31:0]                refs_out_r;

  logic [CNT_W-1:0]           n_frames;
  logic                       in_xfer;
  logic                       out_free;
  logic [PAGE_BITS-1:0]       bus_page;

  cpr_pkg::cell_ctrl_t        ctrl     [MAX_FRAMES];
  cpr_pkg::chain_t            chain    [MAX_FRAMES+1];
  cpr_pkg::chain_t            first    [MAX_FRAMES];
  logic [PAGE_BITS-1:0]       cell_page[MAX_FRAMES];
  logic [MAX_FRAMES-1:0]      cell_use;
  logic [MAX_FRAMES-1:0]      active;
  logic [MAX_FRAMES-1:0]      hit_oh;
  logic [MAX_FRAMES-1:0]      empty_oh;

  logic [IDX_W-1:0]           hit_idx;
  logic [IDX_W-1:0]           empty_idx;
  logic                       hit_any;
  logic                       empty_any;
  logic [IDX_W-1:0]           start_hand;
  logic [CNT_W-1:0]           hand_inc;
  logic [IDX_W-1:0]           hand_next;

  // Decisions for this cycle
  logic                       do_finish;
  logic                       do_start_sweep;
  logic                       do_clear;
  logic                       do_load;
  logic                       do_set_use;
  logic [IDX_W-1:0]           upd_idx;
  logic                       res_hit;
  logic                       res_ev_valid;
  logic [PAGE_BITS-1:0]       res_ev_page;
  logic [31:0]                faults_nxt;
  logic [31:0]                refs_nxt;

  // Clamp the configured frame count into the supported range
  always_comb begin
    if (CMP_W'(cfg_r) < CMP_W'(cpr_pkg::MIN_FRAMES)) begin
      n_frames = CNT_W'(cpr_pkg::MIN_FRAMES);
    end else if (CMP_W'(cfg_r) > CMP_W'(MAX_FRAMES)) begin
      n_frames = CNT_W'(MAX_FRAMES);
    end else begin
      n_frames = CNT_W'(cfg_r);
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign bus_page  = (state_r == S_IDLE) ? in_tdata[PAGE_BITS-1:0] : page_r;

  // Row of frame cells, chained lowest first
  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    assign active[g]   = (CNT_W'(g) < n_frames);
    assign hit_oh[g]   = first[g].hit;
    assign empty_oh[g] = first[g].empty;

    always_comb begin
      ctrl[g].capture = in_xfer;
      ctrl[g].active  = active[g];
      ctrl[g].load    = do_load    && (upd_idx == IDX_W'(g));
      ctrl[g].set_use = do_set_use && (upd_idx == IDX_W'(g));
      ctrl[g].clr_use = do_clear   && (hand_r  == IDX_W'(g));
    end

    cpr_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl[g]),
      .page_in   (bus_page),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .first     (first[g]),
      .page_out  (cell_page[g]),
      .use_out   (cell_use[g])
    );
  end

  assign hit_any   = chain[MAX_FRAMES].hit;
  assign empty_any = chain[MAX_FRAMES].empty;

  // Encode the one-hot winners of the chain
  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (hit_oh[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
      if (empty_oh[i]) begin
        empty_idx = empty_idx | IDX_W'(i);
      end
    end
  end

  // Hand arithmetic: restart at zero when at or beyond the count, wrap at the count
  assign start_hand = (CNT_W'(hand_r) >= n_frames) ? '0 : hand_r;
  assign hand_inc   = CNT_W'(hand_r) + CNT_W'(1);
  assign hand_next  = (hand_inc >= n_frames) ? '0 : hand_inc[IDX_W-1:0];

  // Saturating counters as they stand after the finishing reference
  assign refs_nxt   = (refs_r == '1) ? refs_r : refs_r + 32'd1;
  assign faults_nxt = (res_hit || faults_r == '1) ? faults_r : faults_r + 32'd1;

  // Decide what this cycle does to the frames
  always_comb begin
    do_finish      = 1'b0;
    do_start_sweep = 1'b0;
    do_clear       = 1'b0;
    do_load        = 1'b0;
    do_set_use     = 1'b0;
    upd_idx        = hit_idx;
    res_hit        = 1'b0;
    res_ev_valid   = 1'b0;
    res_ev_page    = '0;
    unique case (state_r)
      S_IDLE: begin
      end
      S_DECIDE: begin
        priority if (hit_any) begin
          res_hit    = 1'b1;
          do_finish  = out_free;
          do_set_use = out_free;
        end else if (empty_any) begin
          upd_idx   = empty_idx;
          do_finish = out_free;
          do_load   = out_free;
        end else begin
          do_start_sweep = 1'b1;
        end
      end
      S_SWEEP: begin
        upd_idx = hand_r;
        if (cell_use[hand_r]) begin
          do_clear = 1'b1;
        end else begin
          res_ev_valid = 1'b1;
          res_ev_page  = cell_page[hand_r];
          do_finish    = out_free;
          do_load      = out_free;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, hand, counters and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= cpr_pkg::CFG_W'(cpr_pkg::MIN_FRAMES);
      hand_r      <= '0;
      faults_r    <= '0;
      refs_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (do_start_sweep) begin
            hand_r  <= start_hand;
            state_r <= S_SWEEP;
          end else if (do_finish) begin
            state_r <= S_IDLE;
          end
        end
        S_SWEEP: begin
          if (do_clear) begin
            hand_r <= hand_next;
          end else if (do_finish) begin
            hand_r  <= hand_next;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (do_finish) begin
        faults_r <= faults_nxt;
        refs_r   <= refs_nxt;
      end
      // Raise the result on finish, drop it once transferred
      if (do_finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Latch the reference and the result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      page_r <= in_tdata[PAGE_BITS-1:0];
    end
    if (do_finish) begin
      hit_out_r      <= res_hit;
      slot_out_r     <= upd_idx;
      ev_valid_out_r <= res_ev_valid;
      ev_page_out_r  <= res_ev_page;
      faults_out_r   <= faults_nxt;
      refs_out_r     <= refs_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = hit_out_r;
  assign out_tdata  = OUT_W'({refs_out_r, faults_out_r, ev_page_out_r,
                              ev_valid_out_r, slot_out_r});

endmodule : clock_page_replacement

`default_nettype wire
